@@ rtl/core/tilt_complementary_filter_unit_assert.svh @@
// Assertion macros shared by the tilt filter RTL.
`ifndef TILT_COMPLEMENTARY_FILTER_UNIT_ASSERT_SVH
`define TILT_COMPLEMENTARY_FILTER_UNIT_ASSERT_SVH

// The property must hold in the same cycle as its trigger.
`define TCF_ASSERT_NOW(name, clk, rst, trig, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |-> (prop)) \
    else $error("tilt filter assertion failed");

// The property must hold in the cycle after its trigger.
`define TCF_ASSERT_NEXT(name, clk, rst, trig, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
    else $error("tilt filter assertion failed");

`endif

@@ rtl/core/tcf_pkg.sv @@
// Types, constants and helper functions of the tilt complementary filter.
package tcf_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int GAIN_W      = 16;
  localparam int SCALE_W     = 32;
  localparam int ACC_ANGLE_W = 19;
  localparam int ANGLE_W     = 32;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int GAIN_FRAC   = 16;

  // CORDIC vector width: inputs are scaled by 2^16 and grow by the CORDIC gain.
  localparam int CORDIC_W = 36;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = 51;
  localparam int SUM_W   = 52;

  localparam logic [GAIN_W-1:0]  FILTER_GAIN_RST = 16'd385;
  localparam logic [SCALE_W-1:0] GYRO_SCALE_RST  = 32'd45703;

  localparam logic signed [MUL_B_W-1:0] GAIN_ONE = 18'sd65536;

  localparam logic signed [SUM_W-1:0] SAT_MAX = 52'sd2147483647;
  localparam logic signed [SUM_W-1:0] SAT_MIN = -52'sd2147483648;

  localparam int ATAN_ENTRIES = 24;
  localparam int ATAN_IDX_W   = 5;

  // Arctangent of 2^-i in units of 2^-32 radians.
  localparam logic [31:0] ATAN_Q32 [ATAN_ENTRIES] = '{
    32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
    32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
    32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
    32'd1048576,    32'd524288,     32'd262144,     32'd131072,
    32'd65536,      32'd32768,      32'd16384,      32'd8192,
    32'd4096,       32'd2048,       32'd1024,       32'd512
  };

  localparam logic [33:0] PI_Q32      = 34'd13493037705;
  localparam logic [33:0] HALF_PI_Q32 = 34'd6746518852;

  typedef enum logic [1:0] {
    MUL_GYRO,
    MUL_LOWPASS,
    MUL_HIGHPASS
  } mul_sel_t;

  typedef struct packed {
    logic                  load;
    logic                  mul_en;
    mul_sel_t              mul_sel;
    logic                  integ;
    logic                  lowpass;
    logic                  highpass;
    logic                  rotate;
    logic [ATAN_IDX_W-1:0] step;
    logic                  commit;
  } tcf_cmd_t;

  // Rounds a Q2.32 angle to frac fraction bits.
  function automatic logic [33:0] q32_to_angle(input logic [33:0] q, input int frac);
    int s;
    s = 32 - frac;
    return (q + (34'd1 << (s - 1))) >> s;
  endfunction

  function automatic logic signed [ANGLE_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    if (v > SAT_MAX) begin
      return 32'sh7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      return 32'sh8000_0000;
    end
    return ANGLE_W'(v);
  endfunction

endpackage

@@ rtl/core/tcf_if.sv @@
// Handshake channels for IMU samples and angle results.
interface tcf_imu_if;
  import tcf_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] accel_y;
  logic signed [SAMPLE_W-1:0] accel_z;
  logic signed [SAMPLE_W-1:0] gyro_rate;

  modport source (output valid, accel_y, accel_z, gyro_rate, input ready);
  modport sink (input valid, accel_y, accel_z, gyro_rate, output ready);
endinterface

interface tcf_angle_if;
  import tcf_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [ACC_ANGLE_W-1:0] accel_angle_raw;
  logic signed [ANGLE_W-1:0]     gyro_angle_raw;
  logic signed [ACC_ANGLE_W-1:0] accel_angle_lowpass;
  logic signed [ANGLE_W-1:0]     gyro_angle_highpass;
  logic signed [ANGLE_W-1:0]     fused_angle;

  modport source (
    output valid, accel_angle_raw, gyro_angle_raw, accel_angle_lowpass,
    output gyro_angle_highpass, fused_angle,
    input ready
  );
  modport sink (
    input valid, accel_angle_raw, gyro_angle_raw, accel_angle_lowpass,
    input gyro_angle_highpass, fused_angle,
    output ready
  );
endinterface

@@ rtl/core/tcf_apb_regs.sv @@
// APB register block holding the filter gain and the gyro scale.
module tcf_apb_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcf_pkg::ADDR_W-1:0]  paddr,
  input  logic [tcf_pkg::DATA_W-1:0]  pwdata,
  output logic [tcf_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output logic [tcf_pkg::GAIN_W-1:0]  filter_gain,
  output logic [tcf_pkg::SCALE_W-1:0] gyro_scale
);
  import tcf_pkg::*;

  localparam logic REG_FILTER_GAIN = 1'b0;
  localparam logic REG_GYRO_SCALE  = 1'b1;

  logic reg_idx;
  logic wr_en;

  assign reg_idx = paddr[ADDR_W-1];
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_gain <= FILTER_GAIN_RST;
      gyro_scale  <= GYRO_SCALE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FILTER_GAIN: filter_gain <= pwdata[GAIN_W-1:0];
        REG_GYRO_SCALE:  gyro_scale  <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FILTER_GAIN: prdata = DATA_W'(filter_gain);
      REG_GYRO_SCALE:  prdata = DATA_W'(gyro_scale);
      default:         prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/tcf_ctrl.sv @@
// Sequencer of the tilt filter: multiplier passes, CORDIC steps and result hand-off.
`include "tilt_complementary_filter_unit_assert.svh"

module tcf_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output tcf_pkg::tcf_cmd_t cmd
);
  import tcf_pkg::*;

  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_GYRO,
    S_INTEG,
    S_LOWPASS,
    S_HIGHPASS,
    S_ROTATE,
    S_FINISH
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] cnt;
  logic [STEP_W-1:0] cnt_next;
  logic              out_valid_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.step   = ATAN_IDX_W'(cnt);
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL_GYRO;
        end
      end
      S_MUL_GYRO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GYRO;
        state_next  = S_INTEG;
      end
      S_INTEG: begin
        cmd.integ   = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LOWPASS;
        state_next  = S_LOWPASS;
      end
      S_LOWPASS: begin
        cmd.lowpass = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_HIGHPASS;
        state_next  = S_HIGHPASS;
      end
      S_HIGHPASS: begin
        cmd.highpass = 1'b1;
        state_next   = S_ROTATE;
      end
      S_ROTATE: begin
        cmd.rotate = 1'b1;
        if (cnt == LAST_STEP) begin
          cnt_next   = '0;
          state_next = S_FINISH;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_FINISH: begin
        // Hold the finished item until the output register is free.
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  `TCF_ASSERT_NEXT(a_accept_goes_busy, clk, rst, in_valid && in_ready, !in_ready)
  `TCF_ASSERT_NOW(a_commit_has_room, clk, rst, cmd.commit, !out_valid || out_ready)
  `TCF_ASSERT_NEXT(a_commit_shows_result, clk, rst, cmd.commit, out_valid)
  `TCF_ASSERT_NOW(a_one_phase, clk, rst, 1'b1,
    $onehot0({cmd.load, cmd.integ, cmd.lowpass, cmd.highpass, cmd.rotate, cmd.commit}))

endmodule

@@ rtl/core/tcf_datapath.sv @@
// Datapath: CORDIC rotator, shared multiplier, filter state and result register.
`include "tilt_complementary_filter_unit_assert.svh"

module tcf_datapath #(
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  tcf_pkg::tcf_cmd_t                        cmd,
  input  logic        [tcf_pkg::GAIN_W-1:0]        filter_gain,
  input  logic        [tcf_pkg::SCALE_W-1:0]       gyro_scale,
  input  logic signed [tcf_pkg::SAMPLE_W-1:0]      accel_y,
  input  logic signed [tcf_pkg::SAMPLE_W-1:0]      accel_z,
  input  logic signed [tcf_pkg::SAMPLE_W-1:0]      gyro_rate,
  output logic signed [tcf_pkg::ACC_ANGLE_W-1:0]   accel_angle_raw,
  output logic signed [tcf_pkg::ANGLE_W-1:0]       gyro_angle_raw,
  output logic signed [tcf_pkg::ACC_ANGLE_W-1:0]   accel_angle_lowpass,
  output logic signed [tcf_pkg::ANGLE_W-1:0]       gyro_angle_highpass,
  output logic signed [tcf_pkg::ANGLE_W-1:0]       fused_angle
);
  import tcf_pkg::*;

  localparam int SHIFT = 32 - ANGLE_FRAC_BITS;
  localparam logic signed [ANGLE_W-1:0] PI_F = ANGLE_W'(q32_to_angle(PI_Q32, ANGLE_FRAC_BITS));
  localparam logic signed [ANGLE_W-1:0] NEG_PI_F = -PI_F;
  localparam logic signed [ANGLE_W-1:0] HALF_PI_F =
    ANGLE_W'(q32_to_angle(HALF_PI_Q32, ANGLE_FRAC_BITS));
  localparam logic signed [PROD_W-1:0] GYRO_HALF = PROD_W'(64'd1 << (SHIFT - 1));
  localparam logic signed [PROD_W-1:0] FILT_HALF = PROD_W'(64'd1 << (GAIN_FRAC - 1));

  // Filter state.
  logic signed [ANGLE_W-1:0] gyro_integral;
  logic signed [ANGLE_W-1:0] prev_accel_angle;
  logic signed [ANGLE_W-1:0] prev_lowpass_out;
  logic signed [ANGLE_W-1:0] prev_highpass_out;

  // Working registers of the current item.
  logic signed [SAMPLE_W-1:0] gr;
  logic                       both_zero;
  logic signed [CORDIC_W-1:0] cx;
  logic signed [CORDIC_W-1:0] cy;
  logic signed [ANGLE_W-1:0]  cang;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ANGLE_W-1:0]  gi_reg;
  logic signed [ANGLE_W-1:0]  lp_reg;
  logic signed [ANGLE_W-1:0]  hp_reg;

  logic signed [16:0]         num;
  logic signed [16:0]         den;
  logic signed [16:0]         x0;
  logic signed [16:0]         y0;
  logic signed [ANGLE_W-1:0]  a0;
  logic signed [CORDIC_W-1:0] x_sh;
  logic signed [CORDIC_W-1:0] y_sh;
  logic signed [ANGLE_W-1:0]  t_ang;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   gyro_rnd;
  logic signed [PROD_W-1:0]   filt_rnd;
  logic signed [ANGLE_W-1:0]  acc_final;

  // atan2(-z, y): vectors in the left half plane are first turned by a quarter turn.
  always_comb begin
    num = 17'sd0 - 17'(accel_z);
    den = 17'(accel_y);
    if (den < 0) begin
      if (num >= 0) begin
        x0 = num;
        y0 = 17'sd0 - den;
        a0 = HALF_PI_F;
      end else begin
        x0 = 17'sd0 - num;
        y0 = den;
        a0 = -HALF_PI_F;
      end
    end else begin
      x0 = den;
      y0 = num;
      a0 = '0;
    end
  end

  assign x_sh  = cx >>> cmd.step;
  assign y_sh  = cy >>> cmd.step;
  assign t_ang = ANGLE_W'(q32_to_angle({2'b00, ATAN_Q32[cmd.step]}, ANGLE_FRAC_BITS));

  always_comb begin
    case (cmd.mul_sel)
      MUL_GYRO: begin
        mul_a = MUL_A_W'(gyro_scale);
        mul_b = MUL_B_W'(gr);
      end
      MUL_LOWPASS: begin
        mul_a = MUL_A_W'(prev_accel_angle) - MUL_A_W'(prev_lowpass_out);
        mul_b = MUL_B_W'(filter_gain);
      end
      MUL_HIGHPASS: begin
        mul_a = MUL_A_W'(prev_highpass_out);
        mul_b = GAIN_ONE - MUL_B_W'(filter_gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign gyro_rnd = (prod + GYRO_HALF) >>> SHIFT;
  assign filt_rnd = (prod + FILT_HALF) >>> GAIN_FRAC;

  always_comb begin
    if (both_zero) begin
      acc_final = '0;
    end else if (cang > PI_F) begin
      acc_final = PI_F;
    end else if (cang < NEG_PI_F) begin
      acc_final = NEG_PI_F;
    end else begin
      acc_final = cang;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      gr        <= gyro_rate;
      both_zero <= (accel_y == 0) && (accel_z == 0);
      cx        <= CORDIC_W'(x0) <<< 16;
      cy        <= CORDIC_W'(y0) <<< 16;
      cang      <= a0;
    end else if (cmd.rotate) begin
      if (cy > 0) begin
        cx   <= cx + y_sh;
        cy   <= cy - x_sh;
        cang <= cang + t_ang;
      end else begin
        cx   <= cx - y_sh;
        cy   <= cy + x_sh;
        cang <= cang - t_ang;
      end
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.integ) begin
      gi_reg <= sat32(SUM_W'(gyro_integral) + SUM_W'(gyro_rnd));
    end
    if (cmd.lowpass) begin
      lp_reg <= sat32(SUM_W'(prev_lowpass_out) + SUM_W'(filt_rnd));
    end
    if (cmd.highpass) begin
      hp_reg <= sat32(SUM_W'(gi_reg) - SUM_W'(gyro_integral) + SUM_W'(filt_rnd));
    end
    if (cmd.commit) begin
      accel_angle_raw     <= acc_final[ACC_ANGLE_W-1:0];
      gyro_angle_raw      <= gi_reg;
      accel_angle_lowpass <= lp_reg[ACC_ANGLE_W-1:0];
      gyro_angle_highpass <= hp_reg;
      fused_angle         <= sat32(SUM_W'(lp_reg) + SUM_W'(hp_reg));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_integral     <= '0;
      prev_accel_angle  <= '0;
      prev_lowpass_out  <= '0;
      prev_highpass_out <= '0;
    end else if (cmd.commit) begin
      gyro_integral     <= gi_reg;
      prev_accel_angle  <= acc_final;
      prev_lowpass_out  <= lp_reg;
      prev_highpass_out <= hp_reg;
    end
  end

  `TCF_ASSERT_NEXT(a_angle_in_range, clk, rst, cmd.commit,
    prev_accel_angle <= PI_F && prev_accel_angle >= NEG_PI_F)

endmodule

@@ rtl/core/tilt_complementary_filter_unit.sv @@
// Each sample passes the multiply, integrate, low-pass, high-pass, rotate and finish states.
// A new sample is taken only after the last one commits; results that stall hold the commit.
// The CORDIC rotator takes one step per cycle after three passes through the one multiplier.
// The output register frees the input side while a result waits to be taken.
// Synchronous reset zeroes the filter state and loads the default gain and gyro scale.
module tilt_complementary_filter_unit #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tcf_pkg::ADDR_W-1:0] paddr,
  input  logic [tcf_pkg::DATA_W-1:0] pwdata,
  output logic [tcf_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  tcf_imu_if.sink                    imu,
  tcf_angle_if.source                angles
);
  import tcf_pkg::*;

  logic [GAIN_W-1:0]  filter_gain;
  logic [SCALE_W-1:0] gyro_scale;
  tcf_cmd_t           cmd;

  tcf_apb_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .filter_gain (filter_gain),
    .gyro_scale  (gyro_scale)
  );

  tcf_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (imu.valid),
    .in_ready  (imu.ready),
    .out_valid (angles.valid),
    .out_ready (angles.ready),
    .cmd       (cmd)
  );

  tcf_datapath #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .filter_gain         (filter_gain),
    .gyro_scale          (gyro_scale),
    .accel_y             (imu.accel_y),
    .accel_z             (imu.accel_z),
    .gyro_rate           (imu.gyro_rate),
    .accel_angle_raw     (angles.accel_angle_raw),
    .gyro_angle_raw      (angles.gyro_angle_raw),
    .accel_angle_lowpass (angles.accel_angle_lowpass),
    .gyro_angle_highpass (angles.gyro_angle_highpass),
    .fused_angle         (angles.fused_angle)
  );

endmodule

@@ tb/sv/tilt_angle_checker.sv @@
// Checker for the tilt complementary filter: predicts and compares every angle result.
`timescale 1ns / 100ps

module tilt_angle_checker #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int GAIN_ADDR       = 0,
  parameter int SCALE_ADDR      = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [tcf_pkg::ADDR_W-1:0] paddr,
  input  logic [tcf_pkg::DATA_W-1:0] pwdata,
  tcf_imu_if                         imu,
  tcf_angle_if                       angles,
  output int                         failures,
  output int                         pending
);
  import tcf_pkg::*;

  localparam logic [15:0] GAIN_AT_RESET  = 16'd385;
  localparam logic [31:0] SCALE_AT_RESET = 32'd45703;
  localparam longint      PI_Q32         = 64'sd13493037705;
  localparam longint      HALF_PI_Q32    = 64'sd6746518852;
  localparam int          ARCTAN_COUNT   = 24;
  localparam longint      WORD_MAX       = 64'sd2147483647;
  localparam longint      WORD_MIN       = -64'sd2147483648;

  typedef struct packed {
    logic signed [ACC_ANGLE_W-1:0] accel_raw;
    logic signed [ANGLE_W-1:0]     gyro_raw;
    logic signed [ACC_ANGLE_W-1:0] accel_lowpass;
    logic signed [ANGLE_W-1:0]     gyro_highpass;
    logic signed [ANGLE_W-1:0]     fused;
  } tilt_angles_t;

  tilt_angles_t expected_angles[$];
  logic [15:0]  filter_gain;
  logic [31:0]  gyro_scale;
  longint       gyro_sum;
  longint       last_accel;
  longint       last_lowpass;
  longint       last_gyro_sum;
  longint       last_highpass;
  int           fail_count = 0;

  function automatic longint arctan_q32(input int i);
    case (i)
      0:       return 64'd3373259426;
      1:       return 64'd1991351318;
      2:       return 64'd1052175346;
      3:       return 64'd534100635;
      4:       return 64'd268086748;
      5:       return 64'd134174063;
      6:       return 64'd67103403;
      7:       return 64'd33553749;
      8:       return 64'd16777131;
      9:       return 64'd8388597;
      10:      return 64'd4194303;
      11:      return 64'd2097152;
      12:      return 64'd1048576;
      13:      return 64'd524288;
      14:      return 64'd262144;
      15:      return 64'd131072;
      16:      return 64'd65536;
      17:      return 64'd32768;
      18:      return 64'd16384;
      19:      return 64'd8192;
      20:      return 64'd4096;
      21:      return 64'd2048;
      22:      return 64'd1024;
      default: return 64'd512;
    endcase
  endfunction

  // Adds half an LSB and floors, so ties round toward plus infinity.
  function automatic longint round_shift(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_word(input longint v);
    if (v > WORD_MAX) begin
      return WORD_MAX;
    end else if (v < WORD_MIN) begin
      return WORD_MIN;
    end
    return v;
  endfunction

  function automatic longint tilt_atan2(input longint num, input longint den);
    longint x, y, ang, nx, ny, step_angle, pi_angle;
    int     i;
    x        = den * 65536;
    y        = num * 65536;
    ang      = 0;
    pi_angle = round_shift(PI_Q32, 32 - ANGLE_FRAC_BITS);
    if (num == 0 && den == 0) begin
      return 0;
    end
    // Rotate the left half plane by a quarter turn so the iterations converge.
    if (x < 0) begin
      if (y >= 0) begin
        nx  = y;
        ny  = -x;
        ang = round_shift(HALF_PI_Q32, 32 - ANGLE_FRAC_BITS);
      end else begin
        nx  = -y;
        ny  = x;
        ang = -round_shift(HALF_PI_Q32, 32 - ANGLE_FRAC_BITS);
      end
      x = nx;
      y = ny;
    end
    for (i = 0; i < CORDIC_STEPS && i < ARCTAN_COUNT; i++) begin
      step_angle = round_shift(arctan_q32(i), 32 - ANGLE_FRAC_BITS);
      if (y > 0) begin
        nx  = x + (y >>> i);
        ny  = y - (x >>> i);
        ang = ang + step_angle;
      end else begin
        nx  = x - (y >>> i);
        ny  = y + (x >>> i);
        ang = ang - step_angle;
      end
      x = nx;
      y = ny;
    end
    if (ang > pi_angle) begin
      ang = pi_angle;
    end
    if (ang < -pi_angle) begin
      ang = -pi_angle;
    end
    return ang;
  endfunction

  task automatic predict_angles(input logic signed [15:0] ay, input logic signed [15:0] az,
                                input logic signed [15:0] rate);
    longint       g, acc, inc, gi, lp, hp;
    tilt_angles_t want;
    g   = longint'(filter_gain);
    acc = tilt_atan2(-longint'(az), longint'(ay));
    inc = round_shift(longint'(rate) * longint'(gyro_scale), 32 - ANGLE_FRAC_BITS);
    gi  = clamp_word(gyro_sum + inc);
    // The low-pass filter works on the previous sample's angle.
    lp  = clamp_word(last_lowpass + round_shift(g * (last_accel - last_lowpass), 16));
    hp  = clamp_word(gi - last_gyro_sum + round_shift(last_highpass * (65536 - g), 16));
    want.accel_raw     = ACC_ANGLE_W'(acc);
    want.gyro_raw      = ANGLE_W'(gi);
    want.accel_lowpass = ACC_ANGLE_W'(lp);
    want.gyro_highpass = ANGLE_W'(hp);
    want.fused         = ANGLE_W'(clamp_word(lp + hp));
    expected_angles.push_back(want);
    gyro_sum      = gi;
    last_accel    = acc;
    last_lowpass  = lp;
    last_gyro_sum = gi;
    last_highpass = hp;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    tilt_angles_t want;
    if (rst) begin
      filter_gain   = GAIN_AT_RESET;
      gyro_scale    = SCALE_AT_RESET;
      gyro_sum      = 0;
      last_accel    = 0;
      last_lowpass  = 0;
      last_gyro_sum = 0;
      last_highpass = 0;
      expected_angles.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == GAIN_ADDR) begin
          filter_gain = pwdata[15:0];
        end else if (paddr == SCALE_ADDR) begin
          gyro_scale = pwdata;
        end
      end
      if (angles.valid && angles.ready) begin
        if (expected_angles.size() == 0) begin
          report_mismatch("unexpected transaction", angles.gyro_angle_raw, '0);
        end else begin
          want = expected_angles.pop_front();
          if (angles.accel_angle_raw !== want.accel_raw) begin
            report_mismatch("accel_angle_raw", angles.accel_angle_raw, want.accel_raw);
          end
          if (angles.gyro_angle_raw !== want.gyro_raw) begin
            report_mismatch("gyro_angle_raw", angles.gyro_angle_raw, want.gyro_raw);
          end
          if (angles.accel_angle_lowpass !== want.accel_lowpass) begin
            report_mismatch("accel_angle_lowpass", angles.accel_angle_lowpass,
                            want.accel_lowpass);
          end
          if (angles.gyro_angle_highpass !== want.gyro_highpass) begin
            report_mismatch("gyro_angle_highpass", angles.gyro_angle_highpass,
                            want.gyro_highpass);
          end
          if (angles.fused_angle !== want.fused) begin
            report_mismatch("fused_angle", angles.fused_angle, want.fused);
          end
        end
      end
      if (imu.valid && imu.ready) begin
        predict_angles(imu.accel_y, imu.accel_z, imu.gyro_rate);
      end
    end
    pending  <= expected_angles.size();
    failures <= fail_count;
  end

endmodule

@@ tb/sv/tb_top.sv @@
// Top of the tilt filter testbench: clock, reset, stimulus, result stalls and verdict.
`timescale 1ns / 100ps

module tb_top;
  import tcf_pkg::*;

  localparam logic [ADDR_W-1:0] GAIN_ADDR   = 3'd0;
  localparam logic [ADDR_W-1:0] SCALE_ADDR  = 3'd4;
  localparam int                STALL_LIMIT = 2000;
  localparam int                BLOCK_ITEMS = 88;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                failures;
  int                pending;
  int                src_idle  = 0;
  int                sink_idle = 0;
  int                stall_cycles = 0;

  tcf_imu_if   imu_ch ();
  tcf_angle_if angle_ch ();

  tilt_complementary_filter_unit uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .imu     (imu_ch),
    .angles  (angle_ch)
  );

  tilt_angle_checker #(
    .GAIN_ADDR  (GAIN_ADDR),
    .SCALE_ADDR (SCALE_ADDR)
  ) checker_i (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .imu      (imu_ch),
    .angles   (angle_ch),
    .failures (failures),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    angle_ch.ready <= !rst && ($urandom_range(99) >= sink_idle);
  end

  always @(posedge clk) begin
    if (rst || (imu_ch.valid && imu_ch.ready) || (angle_ch.valid && angle_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'(int'($urandom_range(8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  // Holds valid across back-to-back transactions; within this task it only drops for a sender gap.
  task automatic send_sample(input logic [15:0] ay, input logic [15:0] az,
                             input logic [15:0] rate);
    if ($urandom_range(99) < src_idle) begin
      imu_ch.valid <= 1'b0;
      repeat ($urandom_range(40, 1)) @(posedge clk);
    end
    imu_ch.valid     <= 1'b1;
    imu_ch.accel_y   <= ay;
    imu_ch.accel_z   <= az;
    imu_ch.gyro_rate <= rate;
    @(posedge clk);
    while (!imu_ch.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    imu_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_filter(input logic [15:0] gain, input logic [31:0] scale);
    drain_results();
    write_reg(GAIN_ADDR, {16'd0, gain});
    write_reg(SCALE_ADDR, scale);
  endtask

  initial begin
    int          blk;
    int          n;
    logic [15:0] gain;
    logic [31:0] scale;
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    imu_ch.valid     = 1'b0;
    imu_ch.accel_y   = '0;
    imu_ch.accel_z   = '0;
    imu_ch.gyro_rate = '0;
    angle_ch.ready   = 1'b0;
    repeat (3) @(posedge clk);
    rst       <= 1'b0;
    src_idle  <= 32;
    sink_idle <= 67;
    @(posedge clk);

    // Directed samples under the reset configuration: quadrant edges and field extremes.
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(-16'sd1000, 16'sd0, 16'sd100);
    send_sample(-16'sd32768, 16'sd0, 16'sd32767);
    send_sample(16'sd32767, 16'sd0, -16'sd32768);
    send_sample(16'sd0, 16'sd32767, 16'sd1);
    send_sample(16'sd0, -16'sd32768, -16'sd1);
    send_sample(16'sd32767, 16'sd32767, 16'sd0);
    send_sample(-16'sd32768, -16'sd32768, 16'sd32767);
    send_sample(-16'sd32768, 16'sd32767, -16'sd32768);
    send_sample(16'sd32767, -16'sd32768, 16'sd12345);
    send_sample(16'sd1, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd1, 16'sd0);
    send_sample(-16'sd1, -16'sd1, 16'sd0);
    send_sample(-16'sd1, 16'sd1, 16'sd0);
    send_sample(16'sd16384, -16'sd28378, 16'sd7);
    send_sample(16'sd100, -16'sd1, -16'sd7);

    // Zero gain freezes the low-pass path; the full gyro scale drives saturation both ways.
    set_filter(16'd0, 32'hFFFF_FFFF);
    send_sample(16'sd500, -16'sd500, 16'sd32767);
    send_sample(-16'sd32768, 16'sd1, 16'sd32767);
    send_sample(16'sd0, 16'sd0, 16'sd32767);
    send_sample(16'sd32767, 16'sd32767, -16'sd32768);
    send_sample(-16'sd7, 16'sd3, -16'sd32768);
    send_sample(16'sd1, -16'sd1, -16'sd32768);

    for (blk = 0; blk < 6; blk++) begin
      case (blk)
        0: begin gain = 16'd65535;               scale = 32'd45703;        end
        1: begin gain = 16'd385;                 scale = 32'hFFFF_FFFF;    end
        2: begin gain = 16'($urandom_range(65535)); scale = $urandom;      end
        3: begin gain = 16'd1;                   scale = 32'd0;            end
        4: begin gain = 16'd32768;               scale = 32'd1 << 20;      end
        default: begin
          gain  = 16'($urandom_range(65535));
          scale = $urandom_range(32'h0010_0000);
        end
      endcase
      set_filter(gain, scale);
      if (blk == 2) begin
        src_idle  <= 67;
        sink_idle <= 32;
      end else if (blk == 4) begin
        src_idle  <= 0;
        sink_idle <= 0;
      end
      for (n = 0; n < BLOCK_ITEMS; n++) begin
        send_sample(pick_sample(), pick_sample(), pick_sample());
      end
    end

    drain_results();
    repeat (30) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
